[design/lock_order_checker_unit_defines.svh]
// assertion macros for the lock order checker
// used by the port checker; expects clk_i and rst_ni in the using scope
`ifndef LOCK_ORDER_CHECKER_UNIT_DEFINES_SVH
`define LOCK_ORDER_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LOC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lock order checker assertion failed");

// next-cycle implication, disabled while in reset
`define LOC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lock order checker assertion failed");

`endif

[design/loc_pkg.sv]
// shared types, codes and sizes of the lock order checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package loc_pkg;

  // table sizes
  localparam int THREAD_SLOTS = 16;
  localparam int STACK_DEPTH  = 8;
  localparam int DEPTH_W      = $clog2(STACK_DEPTH + 1);

  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [3:0]         depth_out_t;

  // configuration register indexes
  localparam logic CFG_LEVEL_MIN = 1'b0;
  localparam logic CFG_LEVEL_MAX = 1'b1;

  localparam logic [7:0] LEVEL_MIN_RST = 8'd0;
  localparam logic [7:0] LEVEL_MAX_RST = 8'd3;

  typedef enum logic [1:0] {
    CMD_ENTER = 2'd0,
    CMD_EXIT  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_RESET = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_ISR           = 3'd1,
    ST_BAD_LEVEL     = 3'd2,
    ST_FULL          = 3'd3,
    ST_ORDER         = 3'd4,
    ST_OVERFLOW      = 3'd5,
    ST_EXIT_MISMATCH = 3'd6
  } status_e;

  // update applied to one cell
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_POP   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] tid;
    logic [7:0]  lvl;
    logic [31:0] key;
    logic        isr;
  } item_t;

  // broadcast to every cell
  typedef struct packed {
    logic [31:0] tid;
    logic [7:0]  lvl;
    logic [31:0] key;
    op_e         op;
    logic        hit;  // target the matching cell, else the lowest free one
  } cell_req_t;

  // state of the matching cell, or-ed along the row
  typedef struct packed {
    logic        hit;
    depth_t      depth;
    logic [7:0]  top_lvl;
    logic [31:0] top_key;
    logic [7:0]  nxt_lvl;
    logic [31:0] nxt_key;
  } cell_view_t;

  typedef struct packed {
    status_e     status;
    depth_out_t  depth_now;
    logic [7:0]  top_level;
    logic [31:0] top_key;
  } result_t;

endpackage

`default_nettype wire

[design/loc_in_if.sv]
// input item channel of the lock order checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface loc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] thread_id;
  logic [7:0]  lock_level;
  logic [31:0] lock_key;
  logic        from_isr;

  modport source (output valid, command, thread_id, lock_level, lock_key, from_isr,
                  input ready);
  modport sink (input valid, command, thread_id, lock_level, lock_key, from_isr,
                output ready);
endinterface

`default_nettype wire

[design/loc_out_if.sv]
// result item channel of the lock order checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface loc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  depth_now;
  logic [7:0]  top_level;
  logic [31:0] top_key;

  modport source (output valid, status, depth_now, top_level, top_key, input ready);
  modport sink (input valid, status, depth_now, top_level, top_key, output ready);
endinterface

`default_nettype wire

[design/loc_cell.sv]
// one thread slot: owner id, depth and a shift-register lock stack
// depends on loc_pkg
`timescale 1ns / 1ps
`default_nettype none

module loc_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  loc_pkg::cell_req_t  req_i,
  input  wire                 free_i,   // some lower cell is free
  output logic                free_o,
  input  loc_pkg::cell_view_t view_i,
  output loc_pkg::cell_view_t view_o
);

  logic              active_q, active_d;
  logic [31:0]       tid_q, tid_d;
  loc_pkg::depth_t   depth_q, depth_d;
  // entry 0 is the top of the stack
  logic [7:0]        lvl_q [loc_pkg::STACK_DEPTH];
  logic [7:0]        lvl_d [loc_pkg::STACK_DEPTH];
  logic [31:0]       key_q [loc_pkg::STACK_DEPTH];
  logic [31:0]       key_d [loc_pkg::STACK_DEPTH];

  logic                match;
  logic                target;
  loc_pkg::cell_view_t own_view;

  localparam int NxtIdx = (loc_pkg::STACK_DEPTH > 1) ? 1 : 0;

  // slot match and lowest-free chain
  assign match  = active_q && (tid_q == req_i.tid);
  assign free_o = free_i || !active_q;
  assign target = req_i.hit ? match : (!active_q && !free_i);

  // pass the matching cell's view along the row
  always_comb begin
    own_view         = '0;
    own_view.hit     = 1'b1;
    own_view.depth   = depth_q;
    own_view.top_lvl = lvl_q[0];
    own_view.top_key = key_q[0];
    own_view.nxt_lvl = lvl_q[NxtIdx];
    own_view.nxt_key = key_q[NxtIdx];
    view_o = view_i;
    if (match) begin
      view_o = loc_pkg::cell_view_t'(view_i | own_view);
    end
  end

  // slot update
  always_comb begin
    active_d = active_q;
    tid_d    = tid_q;
    depth_d  = depth_q;
    lvl_d    = lvl_q;
    key_d    = key_q;
    if (target) begin
      unique case (req_i.op)
        loc_pkg::OP_PUSH: begin
          if (!active_q) begin
            active_d = 1'b1;
            tid_d    = req_i.tid;
          end
          depth_d  = depth_q + loc_pkg::depth_t'(1);
          lvl_d[0] = req_i.lvl;
          key_d[0] = req_i.key;
          for (int i = 1; i < loc_pkg::STACK_DEPTH; i++) begin
            lvl_d[i] = lvl_q[i-1];
            key_d[i] = key_q[i-1];
          end
        end
        loc_pkg::OP_POP: begin
          depth_d = depth_q - loc_pkg::depth_t'(1);
          if (depth_q == loc_pkg::depth_t'(1)) begin
            active_d = 1'b0;
          end
          for (int i = 0; i < loc_pkg::STACK_DEPTH - 1; i++) begin
            lvl_d[i] = lvl_q[i+1];
            key_d[i] = key_q[i+1];
          end
        end
        loc_pkg::OP_CLEAR: begin
          active_d = 1'b0;
          depth_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      depth_q  <= '0;
    end else begin
      active_q <= active_d;
      depth_q  <= depth_d;
    end
  end

  // owner id and stack entries, only read while valid
  always_ff @(posedge clk_i) begin
    tid_q <= tid_d;
    lvl_q <= lvl_d;
    key_q <= key_d;
  end

endmodule

`default_nettype wire

[design/loc_ctrl.sv]
// decision logic: status, cell update and result of one item
// depends on loc_pkg
`timescale 1ns / 1ps
`default_nettype none

module loc_ctrl (
  input  loc_pkg::item_t      item_i,
  input  wire                 fire_i,
  input  wire [7:0]           level_min_i,
  input  wire [7:0]           level_max_i,
  input  loc_pkg::cell_view_t view_i,
  input  wire                 any_free_i,
  output loc_pkg::cell_req_t  req_o,
  output loc_pkg::result_t    res_o
);

  logic            order_ok;
  logic            level_bad;
  logic            top_match;
  logic            at_limit;
  loc_pkg::op_e    op;
  loc_pkg::status_e status;

  // push rule against the current top
  assign order_ok  = !view_i.hit || (item_i.lvl > view_i.top_lvl) ||
                     ((item_i.lvl == view_i.top_lvl) && (item_i.key >= view_i.top_key));
  assign level_bad = (item_i.lvl < level_min_i) || (item_i.lvl > level_max_i);
  assign top_match = view_i.hit && (item_i.lvl == view_i.top_lvl) &&
                     (item_i.key == view_i.top_key);
  assign at_limit  = view_i.depth >= loc_pkg::depth_t'(loc_pkg::STACK_DEPTH);

  // status and update, checks in order
  always_comb begin
    status = loc_pkg::ST_OK;
    op     = loc_pkg::OP_NONE;
    priority if (item_i.isr) begin
      status = loc_pkg::ST_ISR;
    end else if (item_i.cmd != loc_pkg::CMD_RESET && level_bad) begin
      status = loc_pkg::ST_BAD_LEVEL;
    end else begin
      unique case (item_i.cmd)
        loc_pkg::CMD_ENTER: begin
          priority if (!view_i.hit && !any_free_i) begin
            status = loc_pkg::ST_FULL;
          end else if (!order_ok) begin
            status = loc_pkg::ST_ORDER;
          end else if (view_i.hit && at_limit) begin
            status = loc_pkg::ST_OVERFLOW;
          end else begin
            op = loc_pkg::OP_PUSH;
          end
        end
        loc_pkg::CMD_EXIT: begin
          if (top_match) begin
            op = loc_pkg::OP_POP;
          end else begin
            status = loc_pkg::ST_EXIT_MISMATCH;
          end
        end
        loc_pkg::CMD_CHECK: begin
          if (!order_ok) begin
            status = loc_pkg::ST_ORDER;
          end
        end
        loc_pkg::CMD_RESET: begin
          if (view_i.hit) begin
            op = loc_pkg::OP_CLEAR;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // broadcast to the row
  always_comb begin
    req_o     = '0;
    req_o.tid = item_i.tid;
    req_o.lvl = item_i.lvl;
    req_o.key = item_i.key;
    req_o.hit = view_i.hit;
    req_o.op  = fire_i ? op : loc_pkg::OP_NONE;
  end

  // thread view after the step
  always_comb begin
    res_o        = '0;
    res_o.status = status;
    if (view_i.hit) begin
      res_o.depth_now = loc_pkg::depth_out_t'(view_i.depth);
      res_o.top_level = view_i.top_lvl;
      res_o.top_key   = view_i.top_key;
    end
    unique case (op)
      loc_pkg::OP_PUSH: begin
        res_o.depth_now = loc_pkg::depth_out_t'(view_i.hit ? view_i.depth : '0) +
                          loc_pkg::depth_out_t'(1);
        res_o.top_level = item_i.lvl;
        res_o.top_key   = item_i.key;
      end
      loc_pkg::OP_POP: begin
        if (view_i.depth == loc_pkg::depth_t'(1)) begin
          res_o.depth_now = '0;
          res_o.top_level = '0;
          res_o.top_key   = '0;
        end else begin
          res_o.depth_now = loc_pkg::depth_out_t'(view_i.depth - loc_pkg::depth_t'(1));
          res_o.top_level = view_i.nxt_lvl;
          res_o.top_key   = view_i.nxt_key;
        end
      end
      loc_pkg::OP_CLEAR: begin
        res_o.depth_now = '0;
        res_o.top_level = '0;
        res_o.top_key   = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[design/lock_order_checker_unit.sv]
// Lock order checker: a row of thread-slot cells and one decision unit.
// Path: item register, decision against the row, then the output register, which holds while stalled.
// The single item register is compared against the whole cell row and the row is
// updated before the next item is taken.
// Reset: asynchronous, frees every slot at once, level_min 0, level_max 3.
`timescale 1ns / 1ps
`default_nettype none

module lock_order_checker_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  loc_in_if.sink     in_i,
  loc_out_if.source  out_o,
  input  wire        cfg_we_i,
  input  wire        cfg_idx_i,
  input  wire [7:0]  cfg_wdata_i
);

  logic [7:0]       level_min_q;
  logic [7:0]       level_max_q;
  logic             busy_q;
  loc_pkg::item_t   item_q;
  logic             out_valid_q;
  loc_pkg::result_t out_q;

  logic               accept;
  logic               fire;
  loc_pkg::cell_req_t req;
  loc_pkg::result_t   res;

  logic                free_chain [loc_pkg::THREAD_SLOTS + 1];
  loc_pkg::cell_view_t view_chain [loc_pkg::THREAD_SLOTS + 1];

  // handshake
  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && !busy_q;
  assign fire       = busy_q && (!out_valid_q || out_o.ready);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_min_q <= loc_pkg::LEVEL_MIN_RST;
      level_max_q <= loc_pkg::LEVEL_MAX_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == loc_pkg::CFG_LEVEL_MIN) begin
        level_min_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == loc_pkg::CFG_LEVEL_MAX) begin
        level_max_q <= cfg_wdata_i;
      end
    end
  end

  // item register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (fire) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cmd <= loc_pkg::cmd_e'(in_i.command);
      item_q.tid <= in_i.thread_id;
      item_q.lvl <= in_i.lock_level;
      item_q.key <= in_i.lock_key;
      item_q.isr <= in_i.from_isr;
    end
  end

  // row of slot cells
  assign free_chain[0] = 1'b0;
  assign view_chain[0] = '0;

  for (genvar g = 0; g < loc_pkg::THREAD_SLOTS; g++) begin : g_cell
    loc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req),
      .free_i (free_chain[g]),
      .free_o (free_chain[g+1]),
      .view_i (view_chain[g]),
      .view_o (view_chain[g+1])
    );
  end

  // decision
  loc_ctrl u_ctrl (
    .item_i      (item_q),
    .fire_i      (fire),
    .level_min_i (level_min_q),
    .level_max_i (level_max_q),
    .view_i      (view_chain[loc_pkg::THREAD_SLOTS]),
    .any_free_i  (free_chain[loc_pkg::THREAD_SLOTS]),
    .req_o       (req),
    .res_o       (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_q.status;
  assign out_o.depth_now = out_q.depth_now;
  assign out_o.top_level = out_q.top_level;
  assign out_o.top_key   = out_q.top_key;

endmodule

`default_nettype wire

[design/loc_chk.sv]
// port checker of the lock order checker, bound to the top level
// depends on loc_pkg and lock_order_checker_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "lock_order_checker_unit_defines.svh"

module loc_chk (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [2:0]  out_status_i,
  input wire [3:0]  out_depth_i,
  input wire [7:0]  out_top_level_i,
  input wire [31:0] out_top_key_i
);

  logic [46:0] out_payload;
  logic        top_zero;

  // result fields seen as one word
  assign out_payload = {out_status_i, out_depth_i, out_top_level_i, out_top_key_i};
  assign top_zero    = (out_top_level_i == '0) && (out_top_key_i == '0);

  // a stalled result holds
  `LOC_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_payload))

  // one item at a time
  `LOC_ASSERT_NXT(a_in_single, in_valid_i && in_ready_i, !in_ready_i)

  // status codes in range
  `LOC_ASSERT_IMP(a_status_range, out_valid_i, out_status_i <= loc_pkg::ST_EXIT_MISMATCH)

  // depth within the stack size
  `LOC_ASSERT_IMP(a_depth_range, out_valid_i, out_depth_i <= 4'(loc_pkg::STACK_DEPTH))

  // empty stack shows a zero top
  `LOC_ASSERT_IMP(a_empty_top, out_valid_i && out_depth_i == '0, top_zero)

endmodule

bind lock_order_checker_unit loc_chk u_loc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_status_i    (out_o.status),
  .out_depth_i     (out_o.depth_now),
  .out_top_level_i (out_o.top_level),
  .out_top_key_i   (out_o.top_key)
);

`default_nettype wire

[tb/lock_order_checker_unit_checker.sv]
// checker for the lock order checker: tracks the thread table and compares results
// depends on loc_pkg, loc_in_if and loc_out_if
`timescale 1ns / 1ps

module lock_order_checker_unit_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  loc_in_if          in_mon_i,
  loc_out_if         out_mon_i,
  input  wire        cfg_we_i,
  input  wire        cfg_idx_i,
  input  wire [7:0]  cfg_wdata_i,
  output int         fail_count_o,
  output int         pending_o
);
  import loc_pkg::*;

  localparam int PRINT_CAP = 40;

  // own copy of the limits and the thread table
  logic [7:0]  lvl_lo;
  logic [7:0]  lvl_hi;
  logic        slot_used  [THREAD_SLOTS];
  logic [31:0] slot_owner [THREAD_SLOTS];
  int          slot_fill  [THREAD_SLOTS];
  logic [7:0]  stk_lvl    [THREAD_SLOTS][STACK_DEPTH];
  logic [31:0] stk_key    [THREAD_SLOTS][STACK_DEPTH];

  result_t expected_results_q[$];
  int      mismatches = 0;
  item_t   seen_item;
  result_t want_res;

  function automatic int find_owner(logic [31:0] tid);
    for (int s = 0; s < THREAD_SLOTS; s++) begin
      if (slot_used[s] && slot_owner[s] == tid) return s;
    end
    return -1;
  endfunction

  function automatic int lowest_free_slot();
    for (int s = 0; s < THREAD_SLOTS; s++) begin
      if (!slot_used[s]) return s;
    end
    return -1;
  endfunction

  function automatic void release_slot(int s);
    slot_used[s]  = 1'b0;
    slot_owner[s] = '0;
    slot_fill[s]  = 0;
    for (int d = 0; d < STACK_DEPTH; d++) begin
      stk_lvl[s][d] = '0;
      stk_key[s][d] = '0;
    end
  endfunction

  // nesting rule: empty stack or no slot always passes
  function automatic bit nesting_allowed(int s, logic [7:0] lvl, logic [31:0] key);
    int t;
    if (s < 0 || slot_fill[s] == 0) return 1'b1;
    t = slot_fill[s] - 1;
    if (lvl > stk_lvl[s][t]) return 1'b1;
    return (lvl == stk_lvl[s][t]) && (key >= stk_key[s][t]);
  endfunction

  // apply one item to the table and work out the result it gives
  function automatic result_t apply_lock_item(item_t it);
    int      s;
    int      t;
    status_e st;
    result_t r;
    s  = find_owner(it.tid);
    st = ST_OK;
    if (it.isr) begin
      st = ST_ISR;
    end else if (it.cmd != CMD_RESET && (it.lvl < lvl_lo || it.lvl > lvl_hi)) begin
      st = ST_BAD_LEVEL;
    end else begin
      case (it.cmd)
        CMD_ENTER: begin
          if (s < 0) s = lowest_free_slot();
          if (s < 0) begin
            st = ST_FULL;
          end else if (!nesting_allowed(s, it.lvl, it.key)) begin
            st = ST_ORDER;
          end else if (slot_fill[s] >= STACK_DEPTH) begin
            st = ST_OVERFLOW;
          end else begin
            if (!slot_used[s]) begin
              slot_used[s]  = 1'b1;
              slot_owner[s] = it.tid;
              slot_fill[s]  = 0;
            end
            stk_lvl[s][slot_fill[s]] = it.lvl;
            stk_key[s][slot_fill[s]] = it.key;
            slot_fill[s]++;
          end
        end
        CMD_EXIT: begin
          if (s < 0 || slot_fill[s] == 0) begin
            st = ST_EXIT_MISMATCH;
          end else begin
            t = slot_fill[s] - 1;
            if (stk_lvl[s][t] != it.lvl || stk_key[s][t] != it.key) begin
              st = ST_EXIT_MISMATCH;
            end else begin
              stk_lvl[s][t] = '0;
              stk_key[s][t] = '0;
              slot_fill[s]--;
              if (slot_fill[s] == 0) release_slot(s);
            end
          end
        end
        CMD_CHECK: begin
          st = nesting_allowed(s, it.lvl, it.key) ? ST_OK : ST_ORDER;
        end
        default: begin
          if (s >= 0) release_slot(s);
        end
      endcase
    end
    // report the thread's view after the update
    s           = find_owner(it.tid);
    r.status    = st;
    r.depth_now = '0;
    r.top_level = '0;
    r.top_key   = '0;
    if (s >= 0) begin
      r.depth_now = depth_out_t'(slot_fill[s]);
      if (slot_fill[s] > 0) begin
        r.top_level = stk_lvl[s][slot_fill[s] - 1];
        r.top_key   = stk_key[s][slot_fill[s] - 1];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] %0s mismatch: got %0h, expected %0h", $time, field, got, want);
    end
  endtask

  // table update on accepted items, comparison on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_lo = LEVEL_MIN_RST;
      lvl_hi = LEVEL_MAX_RST;
      for (int s = 0; s < THREAD_SLOTS; s++) release_slot(s);
      expected_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_LEVEL_MIN) lvl_lo = cfg_wdata_i;
        else lvl_hi = cfg_wdata_i;
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        seen_item.cmd = cmd_e'(in_mon_i.command);
        seen_item.tid = in_mon_i.thread_id;
        seen_item.lvl = in_mon_i.lock_level;
        seen_item.key = in_mon_i.lock_key;
        seen_item.isr = in_mon_i.from_isr;
        expected_results_q.push_back(apply_lock_item(seen_item));
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_results_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_mon_i.status), 32'hFFFF_FFFF);
        end else begin
          want_res = expected_results_q.pop_front();
          if (out_mon_i.status != want_res.status)
            report_mismatch("status", 32'(out_mon_i.status), 32'(want_res.status));
          if (out_mon_i.depth_now != want_res.depth_now)
            report_mismatch("depth_now", 32'(out_mon_i.depth_now), 32'(want_res.depth_now));
          if (out_mon_i.top_level != want_res.top_level)
            report_mismatch("top_level", 32'(out_mon_i.top_level), 32'(want_res.top_level));
          if (out_mon_i.top_key != want_res.top_key)
            report_mismatch("top_key", out_mon_i.top_key, want_res.top_key);
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_results_q.size();
  end

endmodule

[tb/lock_order_checker_unit_test.sv]
// top of the lock order checker regression: clock, reset, stimulus and verdict
// depends on loc_pkg, the channel interfaces, the block and its checker
`timescale 1ns / 1ps

module lock_order_checker_unit_test;
  import loc_pkg::*;

  localparam int POOL_SIZE  = 20;
  localparam int HOLD_STALL = 80;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_wdata;
  int         fail_count;
  int         pending;

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  // stimulus-side plan of what each pool thread holds
  logic [31:0] thread_ids [POOL_SIZE];
  int          plan_depth [POOL_SIZE];
  logic [7:0]  plan_lvl   [POOL_SIZE][STACK_DEPTH];
  logic [31:0] plan_key   [POOL_SIZE][STACK_DEPTH];
  int          pool_n;
  logic [7:0]  cur_lo;
  logic [7:0]  cur_hi;

  loc_in_if  req_ch ();
  loc_out_if rsp_ch ();

  lock_order_checker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (req_ch),
    .out_o       (rsp_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  lock_order_checker_unit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (req_ch),
    .out_mon_i    (rsp_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_STALL;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  task automatic send_item(cmd_e c, logic [31:0] tid, logic [7:0] lvl, logic [31:0] key,
                           logic isr);
    while (!quiet && $urandom_range(0, 99) < 16) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= c;
    req_ch.thread_id  <= tid;
    req_ch.lock_level <= lvl;
    req_ch.lock_key   <= key;
    req_ch.from_isr   <= isr;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // write both limits once the block has drained
  task automatic set_limits(logic [7:0] lo, logic [7:0] hi);
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_LEVEL_MIN;
    cfg_wdata <= lo;
    @(posedge clk_i);
    cfg_idx   <= CFG_LEVEL_MAX;
    cfg_wdata <= hi;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  function automatic int threads_holding();
    int n;
    n = 0;
    for (int t = 0; t < POOL_SIZE; t++) if (plan_depth[t] > 0) n++;
    return n;
  endfunction

  // edge cases at the default limits of 0 to 3; leaves the table empty
  task automatic directed_items();
    send_item(CMD_ENTER, 32'd1, 8'd0, 32'd0, 1'b1);           // interrupt context
    send_item(CMD_ENTER, 32'd1, 8'd4, 32'd0, 1'b0);           // level above range
    send_item(CMD_EXIT,  32'd1, 8'd0, 32'd0, 1'b0);           // exit without a slot
    send_item(CMD_CHECK, 32'd1, 8'd3, 32'd0, 1'b0);           // check without a slot
    send_item(CMD_RESET, 32'd1, 8'd0, 32'd0, 1'b0);           // reset without a slot
    send_item(CMD_ENTER, 32'd1, 8'd0, 32'd0, 1'b0);
    send_item(CMD_ENTER, 32'd1, 8'd0, 32'd0, 1'b0);           // equal level, equal key
    send_item(CMD_ENTER, 32'd1, 8'd0, 32'd7, 1'b0);
    send_item(CMD_ENTER, 32'd1, 8'd1, 32'd3, 1'b0);
    send_item(CMD_ENTER, 32'd1, 8'd1, 32'd3, 1'b0);
    send_item(CMD_ENTER, 32'd1, 8'd2, 32'd0, 1'b0);
    send_item(CMD_ENTER, 32'd1, 8'd3, 32'd0, 1'b0);
    send_item(CMD_ENTER, 32'd1, 8'd3, 32'hFFFF_FFFF, 1'b0);   // stack now full
    send_item(CMD_ENTER, 32'd1, 8'd3, 32'hFFFF_FFFF, 1'b0);   // overflow
    send_item(CMD_ENTER, 32'd1, 8'd2, 32'd5, 1'b0);           // lower level
    send_item(CMD_CHECK, 32'd1, 8'd3, 32'hFFFF_FFFE, 1'b0);   // lower key, same level
    send_item(CMD_CHECK, 32'd1, 8'd3, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_EXIT,  32'd1, 8'd3, 32'd0, 1'b0);           // top does not match
    send_item(CMD_EXIT,  32'd1, 8'd3, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_ENTER, 32'd0, 8'd1, 32'd1, 1'b0);           // thread id zero
    send_item(CMD_ENTER, 32'hFFFF_FFFF, 8'd2, 32'd2, 1'b0);
    send_item(CMD_EXIT,  32'd0, 8'd1, 32'd1, 1'b0);           // frees at depth zero
    send_item(CMD_RESET, 32'd1, 8'd255, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_RESET, 32'hFFFF_FFFF, 8'd0, 32'd0, 1'b0);
    send_item(CMD_RESET, 32'd1, 8'd0, 32'd0, 1'b1);
  endtask

  // mostly well nested lock sequences, some broken ones and some noise
  task automatic send_random_items(int count);
    int          t;
    int          d;
    int          roll;
    int          enter_pct;
    logic [7:0]  lv;
    logic [7:0]  tl;
    logic [31:0] ky;
    logic [31:0] tk;
    logic [31:0] room;
    cmd_e        c;
    for (int i = 0; i < count; i++) begin
      t    = $urandom_range(0, pool_n - 1);
      d    = plan_depth[t];
      roll = $urandom_range(0, 99);
      tl   = (d > 0) ? plan_lvl[t][d - 1] : 8'd0;
      tk   = (d > 0) ? plan_key[t][d - 1] : 32'd0;
      if (cur_lo > cur_hi || roll < 15) begin
        // noise that leaves the table alone, except thread resets
        case ($urandom_range(0, 3))
          0: send_item(cmd_e'($urandom_range(0, 3)), $urandom, 8'($urandom), $urandom, 1'b1);
          1: send_item(CMD_CHECK, thread_ids[t], 8'($urandom), $urandom, 1'b0);
          2: begin
            send_item(CMD_RESET, thread_ids[t], 8'($urandom), $urandom, 1'b0);
            plan_depth[t] = 0;
          end
          default: begin
            if (cur_lo == 8'd0 && cur_hi == 8'd255) begin
              send_item(CMD_EXIT, thread_ids[t], tl, tk, 1'b1);
            end else begin
              do lv = 8'($urandom); while (!(lv < cur_lo || lv > cur_hi));
              c = cmd_e'($urandom_range(0, 2));
              send_item(c, thread_ids[t], lv, $urandom, 1'b0);
            end
          end
        endcase
      end else if (d > 0 && (tl < cur_lo || tl > cur_hi)) begin
        // stack left over from older limits
        send_item(CMD_RESET, thread_ids[t], 8'($urandom), $urandom, 1'b0);
        plan_depth[t] = 0;
      end else if (roll < 30) begin
        // broken sequences: bad exits and order violations
        if (d == 0) begin
          send_item(CMD_EXIT, thread_ids[t], 8'($urandom_range(cur_lo, cur_hi)), $urandom,
                    1'b0);
        end else begin
          c = ($urandom_range(0, 1) == 0) ? CMD_ENTER : CMD_CHECK;
          if ($urandom_range(0, 1) == 0) begin
            send_item(CMD_EXIT, thread_ids[t], tl, tk ^ (32'd1 << $urandom_range(0, 31)),
                      1'b0);
          end else if (tl > cur_lo) begin
            send_item(c, thread_ids[t], 8'($urandom_range(cur_lo, tl - 1)), $urandom, 1'b0);
          end else if (tk > 0) begin
            send_item(c, thread_ids[t], tl, $urandom_range(0, tk - 1), 1'b0);
          end else begin
            send_item(CMD_EXIT, thread_ids[t], tl, 32'hFFFF_FFFF, 1'b0);
          end
        end
      end else begin
        // well nested enter or matching exit
        enter_pct = (d == 0) ? 100 : (d == STACK_DEPTH) ? 30 : 55;
        if ($urandom_range(0, 99) < enter_pct) begin
          if (d == 0) begin
            lv = 8'($urandom_range(cur_lo, cur_hi));
            ky = $urandom;
          end else begin
            lv = ($urandom_range(0, 2) == 0) ? tl : 8'($urandom_range(tl, cur_hi));
            if (lv == tl) begin
              room = ~tk;
              if (room > 32'd1000) room = 32'd1000;
              ky = tk + $urandom_range(0, room);
            end else begin
              ky = $urandom;
            end
          end
          send_item(CMD_ENTER, thread_ids[t], lv, ky, 1'b0);
          // registry full and overflow leave the stack as it was
          if (d < STACK_DEPTH && (d > 0 || threads_holding() < THREAD_SLOTS)) begin
            plan_lvl[t][d] = lv;
            plan_key[t][d] = ky;
            plan_depth[t]  = d + 1;
          end
        end else begin
          send_item(CMD_EXIT, thread_ids[t], tl, tk, 1'b0);
          plan_depth[t] = d - 1;
        end
      end
    end
  endtask

  // main sequence
  initial begin
    bit fresh;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_LEVEL_MIN;
    cfg_wdata         = 8'd0;
    req_ch.valid      = 1'b0;
    req_ch.command    = CMD_ENTER;
    req_ch.thread_id  = 32'd0;
    req_ch.lock_level = 8'd0;
    req_ch.lock_key   = 32'd0;
    req_ch.from_isr   = 1'b0;
    cur_lo            = LEVEL_MIN_RST;
    cur_hi            = LEVEL_MAX_RST;

    // distinct thread ids, the extremes among them
    thread_ids[0] = 32'd0;
    thread_ids[1] = 32'hFFFF_FFFF;
    for (int t = 2; t < POOL_SIZE; t++) begin
      do begin
        thread_ids[t] = $urandom;
        fresh = 1'b1;
        for (int u = 0; u < t; u++) if (thread_ids[u] == thread_ids[t]) fresh = 1'b0;
      end while (!fresh);
    end
    for (int t = 0; t < POOL_SIZE; t++) plan_depth[t] = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_limits(8'd0, 8'd3);
    directed_items();
    pool_n = 6;
    send_random_items(90);

    // full level range with no idling on either side
    set_limits(8'd0, 8'd255);
    quiet  = 1'b1;
    pool_n = POOL_SIZE;
    send_random_items(110);
    quiet  = 1'b0;

    // single level, so nesting rests on the key order
    set_limits(8'd5, 8'd5);
    pool_n = 8;
    send_random_items(60);

    // inverted range, every level is bad
    set_limits(8'd9, 8'd2);
    send_random_items(30);

    set_limits(8'd255, 8'd255);
    pool_n = POOL_SIZE;
    send_random_items(50);

    // back to defaults with a long result hold-off
    set_limits(8'd0, 8'd3);
    hold_req = 1'b1;
    send_random_items(110);

    // drain
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
